/* src/mcs_pkg.sv */
// Shared types and constants for the motion command supervisor.
// No dependencies; imported by every module of the block.
package mcs_pkg;

    localparam int MAX_CLIENTS = 8;
    localparam int LENGTH_BITS = 16;
    localparam int CLIENT_W    = $clog2(MAX_CLIENTS);
    localparam int BYTE_W      = 8;
    localparam int CFG_W       = 16;
    localparam int NUM_W       = 16;
    localparam int TIMER_W     = 16;

    localparam logic [BYTE_W-1:0] CH_QUOTE   = 8'h22;
    localparam logic [BYTE_W-1:0] CH_N       = 8'h4E;
    localparam logic [BYTE_W-1:0] CH_COLON   = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [3*BYTE_W-1:0] KEY_PATTERN = {CH_QUOTE, CH_N, CH_QUOTE};

    // key counts only if its quote sits more than this many bytes before the end
    localparam int KEY_SPAN = 6;

    typedef enum logic [1:0] {
        MODE_TICK       = 2'd0,
        MODE_CONNECT    = 2'd1,
        MODE_DISCONNECT = 2'd2,
        MODE_BYTE       = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ACT_FORWARD = 2'd0,
        ACT_DROP    = 2'd1,
        ACT_ESTOP   = 2'd2,
        ACT_REJECT  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_RATE_LIMIT = 2'd0,
        CFG_WATCHDOG   = 2'd1,
        CFG_SETPOINT   = 2'd2,
        CFG_DIRECT     = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_BLANKS = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [CFG_W-1:0] rate_limit_ms;
        logic [CFG_W-1:0] watchdog_ms;
        logic [CFG_W-1:0] setpoint_code;
        logic [CFG_W-1:0] direct_code;
    } t_cfg;

    typedef struct packed {
        t_mode               mode;
        logic [CLIENT_W-1:0] client;
        logic [BYTE_W-1:0]   data_byte;
        logic                last_byte;
    } t_item;

    typedef struct packed {
        t_action action;
        logic    add_newline;
        logic    is_motion;
    } t_result;

    typedef struct packed {
        logic byte_en;   // controller byte, scanner advances
        logic clear;     // connect or disconnect wipes the scanner
    } t_scan_ctl;

    typedef struct packed {
        logic motion;    // finished message is a motion command
        logic add_nl;    // last byte was not a newline
    } t_scan_res;

endpackage

/* src/mcs_cfg.sv */
// Configuration register file of the motion command supervisor.
// Depends on mcs_pkg.
module mcs_cfg (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  logic [1:0]               i_cfg_index,
    input  logic [mcs_pkg::CFG_W-1:0] i_cfg_data,
    output logic                     o_cfg_ready,
    output mcs_pkg::t_cfg            o_cfg
);
    import mcs_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_limit_ms <= CFG_W'(20);
            r_cfg.watchdog_ms   <= CFG_W'(500);
            r_cfg.setpoint_code <= CFG_W'(200);
            r_cfg.direct_code   <= CFG_W'(999);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RATE_LIMIT: r_cfg.rate_limit_ms <= i_cfg_data;
                CFG_WATCHDOG:   r_cfg.watchdog_ms   <= i_cfg_data;
                CFG_SETPOINT:   r_cfg.setpoint_code <= i_cfg_data;
                CFG_DIRECT:     r_cfg.direct_code   <= i_cfg_data;
                default:        ;
            endcase
        end
    end

endmodule

/* src/mcs_scan.sv */
// Message scanner: finds the first "N": key and parses its decimal value.
// Depends on mcs_pkg; driven by mcs_ctrl through the top level.
module mcs_scan (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mcs_pkg::t_scan_ctl         i_ctl,
    input  logic [mcs_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_last,
    input  mcs_pkg::t_cfg              i_cfg,
    output mcs_pkg::t_scan_res         o_res
);
    import mcs_pkg::*;

    localparam int LEN_W = LENGTH_BITS;
    localparam int NV_W  = NUM_W + 4;

    t_phase                 r_phase, n_phase;
    logic [3*BYTE_W-1:0]    r_recent, n_recent;
    logic [LEN_W-1:0]       r_len, n_len;
    logic [LEN_W-1:0]       r_keypos, n_keypos;
    logic [NUM_W-1:0]       r_num, n_num;

    logic                   digit;
    logic [3:0]             digit_val;
    logic [NV_W-1:0]        nv;

    assign digit     = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign digit_val = 4'(i_byte - CH_ZERO);
    // times ten as two shifts
    assign nv = (NV_W'(r_num) << 3) + (NV_W'(r_num) << 1) + NV_W'(digit_val);

    // next state of the scanner for one byte
    always_comb begin
        n_phase  = r_phase;
        n_recent = r_recent;
        n_len    = r_len;
        n_keypos = r_keypos;
        n_num    = r_num;
        if (i_ctl.byte_en) begin
            unique case (r_phase)
                PH_SEARCH: begin
                    if (r_recent == KEY_PATTERN && i_byte == CH_COLON) begin
                        n_keypos = (r_len >= LEN_W'(3)) ? r_len - LEN_W'(3) : '0;
                        n_num    = '0;
                        n_phase  = PH_BLANKS;
                    end
                end
                PH_BLANKS: begin
                    if (digit) begin
                        n_num   = NUM_W'(digit_val);
                        n_phase = PH_DIGITS;
                    end else if (i_byte != CH_SPACE && i_byte != CH_TAB) begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DIGITS: begin
                    if (digit) begin
                        n_num = (nv > NV_W'({NUM_W{1'b1}})) ? '1 : nv[NUM_W-1:0];
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DONE: ;
                default: ;
            endcase
            n_recent = {r_recent[2*BYTE_W-1:0], i_byte};
            if (r_len != '1) n_len = r_len + LEN_W'(1);
        end
    end

    // verdict on the message as it stands after this byte
    always_comb begin
        o_res.motion = (n_phase != PH_SEARCH)
                    && ((LEN_W+1)'(n_keypos) + (LEN_W+1)'(KEY_SPAN) < (LEN_W+1)'(n_len))
                    && (n_num == i_cfg.setpoint_code || n_num == i_cfg.direct_code);
        o_res.add_nl = (i_byte != CH_NEWLINE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear || (i_ctl.byte_en && i_last)) begin
            r_phase  <= PH_SEARCH;
            r_recent <= '0;
            r_len    <= '0;
            r_keypos <= '0;
            r_num    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_recent <= n_recent;
            r_len    <= n_len;
            r_keypos <= n_keypos;
            r_num    <= n_num;
        end
    end

endmodule

/* src/mcs_ctrl.sv */
// Supervisor core: controller slot, dead-man watchdog, rate limiter, verdicts.
// Depends on mcs_pkg; consumes the scanner verdict from mcs_scan.
module mcs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  mcs_pkg::t_item      i_item,
    input  mcs_pkg::t_cfg       i_cfg,
    input  mcs_pkg::t_scan_res  i_scan,
    output mcs_pkg::t_scan_ctl  o_scan_ctl,
    output logic                o_res_valid,
    output mcs_pkg::t_result    o_res
);
    import mcs_pkg::*;

    logic                r_slot, n_slot;
    logic [CLIENT_W-1:0] r_id, n_id;
    logic                r_armed, n_armed;
    logic                r_tripped, n_tripped;
    logic [TIMER_W-1:0]  r_since_motion, n_since_motion;
    logic [TIMER_W-1:0]  r_since_fwd, n_since_fwd;

    logic [TIMER_W-1:0]  sm_inc, sf_inc;
    logic                is_ctrl;
    logic                client_ok;

    assign sm_inc  = (r_since_motion == '1) ? r_since_motion : r_since_motion + TIMER_W'(1);
    assign sf_inc  = (r_since_fwd == '1) ? r_since_fwd : r_since_fwd + TIMER_W'(1);
    assign is_ctrl = r_slot && (r_id == i_item.client);
    // clients past the supported count are ignored; the controller id is always in range
    assign client_ok = int'(i_item.client) < MAX_CLIENTS;

    always_comb begin
        n_slot         = r_slot;
        n_id           = r_id;
        n_armed        = r_armed;
        n_tripped      = r_tripped;
        n_since_motion = r_since_motion;
        n_since_fwd    = r_since_fwd;
        o_scan_ctl     = '0;
        o_res_valid    = 1'b0;
        o_res          = '{action: ACT_FORWARD, add_newline: 1'b0, is_motion: 1'b0};
        if (i_fire) begin
            case (i_item.mode)
                MODE_TICK: begin
                    n_since_motion = sm_inc;
                    n_since_fwd    = sf_inc;
                    if (r_slot && r_armed && !r_tripped && sm_inc >= i_cfg.watchdog_ms) begin
                        n_tripped    = 1'b1;
                        o_res_valid  = 1'b1;
                        o_res.action = ACT_ESTOP;
                    end
                end
                MODE_CONNECT: begin
                    if (client_ok && r_slot) begin
                        o_res_valid  = 1'b1;
                        o_res.action = ACT_REJECT;
                    end else if (client_ok) begin
                        n_slot           = 1'b1;
                        n_id             = i_item.client;
                        n_armed          = 1'b1;
                        n_tripped        = 1'b0;
                        n_since_motion   = '0;
                        o_scan_ctl.clear = 1'b1;
                    end
                end
                MODE_DISCONNECT: begin
                    if (is_ctrl) begin
                        n_slot           = 1'b0;
                        n_id             = '0;
                        n_armed          = 1'b0;
                        n_tripped        = 1'b0;
                        n_since_motion   = '0;
                        o_scan_ctl.clear = 1'b1;
                        o_res_valid      = 1'b1;
                        o_res.action     = ACT_ESTOP;
                    end
                end
                MODE_BYTE: begin
                    if (is_ctrl) begin
                        o_scan_ctl.byte_en = 1'b1;
                        if (i_item.last_byte) begin
                            o_res_valid = 1'b1;
                            if (i_scan.motion) begin
                                n_since_motion  = '0;
                                n_armed         = 1'b1;
                                n_tripped       = 1'b0;
                                o_res.is_motion = 1'b1;
                                if (r_since_fwd < i_cfg.rate_limit_ms) begin
                                    o_res.action = ACT_DROP;
                                end else begin
                                    n_since_fwd       = '0;
                                    o_res.add_newline = i_scan.add_nl;
                                end
                            end else begin
                                o_res.add_newline = i_scan.add_nl;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot         <= 1'b0;
            r_id           <= '0;
            r_armed        <= 1'b0;
            r_tripped      <= 1'b0;
            r_since_motion <= '0;
            r_since_fwd    <= '1;
        end else begin
            r_slot         <= n_slot;
            r_id           <= n_id;
            r_armed        <= n_armed;
            r_tripped      <= n_tripped;
            r_since_motion <= n_since_motion;
            r_since_fwd    <= n_since_fwd;
        end
    end

endmodule

/* src/motion_command_supervisor_top.sv */
// Motion command supervisor, top level: stream ports, input and result registers.
// Depends on mcs_pkg, mcs_cfg, mcs_scan and mcs_ctrl.
//
// Takes one word per clock, back to back, unless the master side stalls: a
// tick, a connect, a disconnect or a message byte. Each word is held in an
// input register, decided combinationally by the slot/watchdog logic and the
// byte scanner, and its verdict (if any) lands in the result register, which
// drives the master side. The result register frees the input side: a new
// word is taken while a verdict waits, and backpressure on the master side
// stalls the input only once both registers are full. Ticks, connects and
// non-final bytes usually yield no verdict. Configuration writes are taken
// every cycle and should only be issued while the block is idle.
module motion_command_supervisor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [2:0] client, [10:3] data_byte, [15:11] zero
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] mode
    input  logic        i_s_axis_tlast,   // last_byte
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [1:0] action, [2] add_newline, [3] is_motion
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import mcs_pkg::*;

    logic      r_in_valid;
    t_item     r_in;
    logic      r_out_valid;
    t_result   r_out;

    logic      adv;
    logic      fire;
    t_cfg      cfg;
    t_scan_ctl scan_ctl;
    t_scan_res scan_res;
    logic      res_valid;
    t_result   res;

    assign adv             = !r_out_valid || i_m_axis_tready;
    assign fire            = r_in_valid && adv;
    assign o_s_axis_tready = !r_in_valid || adv;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0, r_out.is_motion, r_out.add_newline, r_out.action};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in.mode      <= t_mode'(i_s_axis_tuser);
            r_in.client    <= i_s_axis_tdata[CLIENT_W-1:0];
            r_in.data_byte <= i_s_axis_tdata[CLIENT_W +: BYTE_W];
            r_in.last_byte <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= fire && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    mcs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    mcs_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_byte  (r_in.data_byte),
        .i_last  (r_in.last_byte),
        .i_cfg   (cfg),
        .o_res   (scan_res)
    );

    mcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in),
        .i_cfg       (cfg),
        .i_scan      (scan_res),
        .o_scan_ctl  (scan_ctl),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

endmodule

/* src/mcs_checker.sv */
// Port-level checks for the motion command supervisor, bound to the top level.
// Depends on mcs_pkg and motion_command_supervisor_top.
module mcs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata
);
    import mcs_pkg::*;

    // a stalled verdict word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("verdict word changed while stalled");

    // only message verdicts may carry the motion flag
    a_motion_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[3] |->
            (o_m_axis_tdata[1:0] == ACT_FORWARD || o_m_axis_tdata[1:0] == ACT_DROP))
        else $error("motion flag on a non-message verdict");

    // a rate-limited drop is always a motion command and never adds a newline
    a_drop_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1:0] == ACT_DROP |->
            o_m_axis_tdata[3] && !o_m_axis_tdata[2])
        else $error("drop verdict without motion flag");

    // newline request only with a forward
    a_newline_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[2] |-> o_m_axis_tdata[1:0] == ACT_FORWARD)
        else $error("newline request on a non-forward verdict");

endmodule

bind motion_command_supervisor_top mcs_checker u_mcs_checker (.*);

/* sim/tb_motion_command_supervisor_top.sv */
// Testbench for motion_command_supervisor_top: directed and random traffic against a
// cycle-free predictor of slot, watchdog, rate limit and key scanning behavior.
// Depends on mcs_pkg and the RTL under src/.
`timescale 1ns / 100ps

module tb_motion_command_supervisor_top;
    import mcs_pkg::*;

    localparam int          RANDOM_WORDS = 1300;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned LEN_MAX      = (1 << LENGTH_BITS) - 1;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata  = '0;
    logic [1:0]  i_s_axis_tuser  = '0;
    logic        i_s_axis_tlast  = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b1;
    logic [7:0]  o_m_axis_tdata;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index     = '0;
    logic [15:0] i_cfg_data      = '0;

    motion_command_supervisor_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // supervisor state as the predictor sees it
    t_cfg        cfg_now;
    logic        slot_taken;
    logic [2:0]  ctrl_id;
    logic        wd_armed;
    logic        wd_tripped;
    logic [15:0] since_motion;
    logic [15:0] since_forward;
    t_phase      scan_phase;
    logic [23:0] recent;
    int unsigned msg_len;
    int unsigned key_pos;
    int unsigned number;

    t_result verdict_q[$];
    int      mismatches   = 0;
    int      words_sent   = 0;
    int      random_words = 0;
    int      verdicts     = 0;
    int      action_tally[4];
    int      cycle_count  = 0;
    int      rx_hold      = 0;
    int      rx_draw;
    bit      calm         = 1'b0;
    bit      in_random    = 1'b0;

    function automatic void clear_scanner();
        scan_phase = PH_SEARCH;
        recent     = '0;
        msg_len    = 0;
        key_pos    = 0;
        number     = 0;
    endfunction

    function automatic void reset_model();
        cfg_now       = {16'd20, 16'd500, 16'd200, 16'd999};
        slot_taken    = 1'b0;
        ctrl_id       = '0;
        wd_armed      = 1'b0;
        wd_tripped    = 1'b0;
        since_motion  = '0;
        since_forward = '1;
        clear_scanner();
    endfunction

    // returns 1 when the word yields a verdict
    function automatic bit predict_verdict(input t_item w, output t_result r);
        logic digit;
        logic motion;
        r = '0;
        if (w.mode == MODE_TICK) begin
            if (since_motion != 16'hFFFF) since_motion++;
            if (since_forward != 16'hFFFF) since_forward++;
            if (slot_taken && wd_armed && !wd_tripped && since_motion >= cfg_now.watchdog_ms) begin
                wd_tripped = 1'b1;
                r.action = ACT_ESTOP;
                return 1'b1;
            end
            return 1'b0;
        end
        if (int'(w.client) >= MAX_CLIENTS) return 1'b0;
        case (w.mode)
            MODE_CONNECT: begin
                if (slot_taken) begin
                    r.action = ACT_REJECT;
                    return 1'b1;
                end
                slot_taken   = 1'b1;
                ctrl_id      = w.client;
                wd_armed     = 1'b1;
                wd_tripped   = 1'b0;
                since_motion = '0;
                clear_scanner();
                return 1'b0;
            end
            MODE_DISCONNECT: begin
                if (!slot_taken || ctrl_id != w.client) return 1'b0;
                slot_taken   = 1'b0;
                ctrl_id      = '0;
                wd_armed     = 1'b0;
                wd_tripped   = 1'b0;
                since_motion = '0;
                clear_scanner();
                r.action = ACT_ESTOP;
                return 1'b1;
            end
            default: begin
                if (!slot_taken || ctrl_id != w.client) return 1'b0;
                digit = (w.data_byte >= CH_ZERO) && (w.data_byte <= CH_NINE);
                case (scan_phase)
                    PH_SEARCH: begin
                        if (recent == KEY_PATTERN && w.data_byte == CH_COLON) begin
                            key_pos    = (msg_len >= 3) ? msg_len - 3 : 0;
                            number     = 0;
                            scan_phase = PH_BLANKS;
                        end
                    end
                    PH_BLANKS: begin
                        if (digit) begin
                            number     = 32'(w.data_byte - CH_ZERO);
                            scan_phase = PH_DIGITS;
                        end else if (w.data_byte != CH_SPACE && w.data_byte != CH_TAB) begin
                            scan_phase = PH_DONE;
                        end
                    end
                    PH_DIGITS: begin
                        if (digit) begin
                            number = number * 10 + 32'(w.data_byte - CH_ZERO);
                            if (number > 32'hFFFF) number = 32'hFFFF;
                        end else begin
                            scan_phase = PH_DONE;
                        end
                    end
                    default: ;
                endcase
                recent = {recent[15:0], w.data_byte};
                if (msg_len < LEN_MAX) msg_len++;
                if (!w.last_byte) return 1'b0;
                motion = (scan_phase != PH_SEARCH) && (key_pos + KEY_SPAN < msg_len) &&
                         (number == 32'(cfg_now.setpoint_code) ||
                          number == 32'(cfg_now.direct_code));
                clear_scanner();
                if (motion) begin
                    since_motion = '0;
                    wd_armed     = 1'b1;
                    wd_tripped   = 1'b0;
                    r.is_motion  = 1'b1;
                    if (since_forward < cfg_now.rate_limit_ms) begin
                        r.action = ACT_DROP;
                        return 1'b1;
                    end
                    since_forward = '0;
                end
                r.action      = ACT_FORWARD;
                r.add_newline = (w.data_byte != CH_NEWLINE);
                return 1'b1;
            end
        endcase
    endfunction

    // result side: random stalls after each accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b1;
            rx_hold         <= 0;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            rx_draw = calm ? 0 : $urandom_range(0, 4);
            rx_hold         <= rx_draw;
            i_m_axis_tready <= (rx_draw == 0);
        end else if (rx_hold != 0) begin
            rx_hold         <= rx_hold - 1;
            i_m_axis_tready <= (rx_hold == 1);
        end
    end

    // verdict checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                $error("verdict %h arrived with none pending", o_m_axis_tdata);
                mismatches++;
            end else begin
                want = verdict_q.pop_front();
                verdicts++;
                action_tally[want.action]++;
                if (o_m_axis_tdata[1:0] !== want.action) begin
                    $error("action: expected %0d, got %0d", want.action, o_m_axis_tdata[1:0]);
                    mismatches++;
                end
                if (o_m_axis_tdata[2] !== want.add_newline) begin
                    $error("add_newline: expected %0d, got %0d", want.add_newline,
                           o_m_axis_tdata[2]);
                    mismatches++;
                end
                if (o_m_axis_tdata[3] !== want.is_motion) begin
                    $error("is_motion: expected %0d, got %0d", want.is_motion,
                           o_m_axis_tdata[3]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts pending", cycle_count,
                     verdict_q.size());
            $display("** motion_command_supervisor_top: FAILED **");
            $finish;
        end
    end

    task automatic send_word(input t_item w);
        t_result r;
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {5'b0, w.data_byte, w.client};
        i_s_axis_tuser  <= w.mode;
        i_s_axis_tlast  <= w.last_byte;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        if (predict_verdict(w, r)) verdict_q.push_back(r);
        words_sent++;
        if (in_random) random_words++;
    endtask

    // tick, connect or disconnect; byte and last carry junk the block must ignore
    task automatic send_event(input t_mode m, input logic [2:0] cl);
        t_item w;
        w.mode      = m;
        w.client    = cl;
        w.data_byte = 8'($urandom_range(0, 255));
        w.last_byte = 1'($urandom_range(0, 1));
        send_word(w);
    endtask

    task automatic send_stray();
        t_item w;
        w.mode      = ($urandom_range(0, 1) != 0) ? MODE_TICK : MODE_BYTE;
        w.client    = 3'(ctrl_id + $urandom_range(1, 7));
        w.data_byte = 8'($urandom_range(0, 255));
        w.last_byte = 1'($urandom_range(0, 1));
        send_word(w);
    endtask

    // one message, last set on its final byte; optionally laced with ticks and other clients
    task automatic send_text(input logic [2:0] cl, input string s, input bit mixed);
        t_item w;
        for (int i = 0; i < s.len(); i++) begin
            if (mixed && $urandom_range(0, 7) == 0) send_stray();
            w.mode      = MODE_BYTE;
            w.client    = cl;
            w.data_byte = s[i];
            w.last_byte = (i == s.len() - 1);
            send_word(w);
        end
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // writes all four registers, index order
    task automatic write_config(input t_cfg c);
        t_cfg_idx    idx;
        logic [15:0] val;
        for (int k = 0; k < 4; k++) begin
            idx = t_cfg_idx'(k);
            val = c[(3 - k) * 16 +: 16];
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= val;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            cfg_now[(3 - k) * 16 +: 16] = val;
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic shuffle_config();
        logic [15:0] rl, wd, sp, dc;
        case ($urandom_range(0, 7))
            0:       rl = 16'd0;
            1:       rl = 16'hFFFF;
            default: rl = 16'($urandom_range(0, 30));
        endcase
        case ($urandom_range(0, 9))
            0:       wd = 16'hFFFF;
            1:       wd = 16'd1;
            default: wd = 16'($urandom_range(1, 15));
        endcase
        sp = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(0, 999));
        dc = ($urandom_range(0, 7) == 0) ? 16'hFFFE : 16'($urandom_range(0, 999));
        drain();
        write_config({rl, wd, sp, dc});
    endtask

    function automatic string make_message();
        string head, blanks, num, tail, msg;
        int unsigned v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: head = "{\"N\":";
            4:          head = "{\"T\":1,\"N\":";
            5:          head = "\"N\":";
            6:          head = "{\"H\":\"N\",\"N\":";
            7:          head = "{\"N\" :";
            8:          head = "{N\":";
            default:    head = "{\"n\":";
        endcase
        blanks = "";
        repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 1) != 0) blanks = $sformatf("%s ", blanks);
            else blanks = $sformatf("%s\t", blanks);
        end
        case ($urandom_range(0, 7))
            0, 1, 2: v = 32'(cfg_now.setpoint_code);
            3, 4:    v = 32'(cfg_now.direct_code);
            5:       v = $urandom_range(0, 65535);
            6:       v = $urandom_range(0, 20);
            default: v = 65530 + $urandom_range(0, 9999999);
        endcase
        if ($urandom_range(0, 15) == 0) num = "";
        else num = $sformatf("%0d", v);
        case ($urandom_range(0, 5))
            0, 1:    tail = "}";
            2:       tail = ",\"D1\":5,\"D2\":-3}";
            3:       tail = ",\"N\":200}";
            4:       tail = "";
            default: tail = "x}";
        endcase
        msg = $sformatf("%s%s%s%s", head, blanks, num, tail);
        if ($urandom_range(0, 1) != 0) msg = $sformatf("%s\n", msg);
        if ($urandom_range(0, 9) == 0)
            msg.putc($urandom_range(0, msg.len() - 1), 8'($urandom_range(1, 255)));
        return msg;
    endfunction

    task automatic test_first_motion_after_boot();
        send_event(MODE_CONNECT, 3'd3);
        send_text(3'd3, "{\"N\":200}\n", 1'b0);
        send_text(3'd3, "{\"N\":999}", 1'b0);
    endtask

    task automatic test_slot_events();
        send_event(MODE_CONNECT, 3'd5);
        send_event(MODE_CONNECT, 3'd3);
        send_event(MODE_DISCONNECT, 3'd6);
        send_text(3'd6, "{\"N\":200}", 1'b0);
        send_event(MODE_DISCONNECT, 3'd3);
        send_event(MODE_DISCONNECT, 3'd3);
        send_event(MODE_CONNECT, 3'd7);
    endtask

    task automatic test_key_scanning();
        drain();
        write_config({16'd0, 16'hFFFF, 16'd0, 16'd2});
        send_text(3'd7, "\n", 1'b0);
        send_text(3'd7, "{\"N\":\t 2}", 1'b0);
        send_text(3'd7, "{\"N\":}", 1'b0);          // no digits reads as zero
        send_text(3'd7, "{\"N\": x}\n", 1'b0);
        send_text(3'd7, "{\"N\":99999999}", 1'b0);  // value pins at 65535
        send_text(3'd7, "\"N\":2\n", 1'b0);         // key one byte too close to the end
        send_text(3'd7, "\"N\":2}\n", 1'b0);
        send_text(3'd7, "{\"N\":7,\"N\":2}", 1'b0);  // only the first key counts
        send_text(3'd7, "{\"N\" :2}", 1'b0);
        send_text(3'd7, "{N\":2}", 1'b0);
    endtask

    task automatic test_watchdog();
        drain();
        write_config({16'd0, 16'd1, 16'd200, 16'd2});
        send_text(3'd7, "{\"N\":2}", 1'b0);
        repeat (2) send_event(MODE_TICK, 3'd0);
        drain();
        write_config({16'd0, 16'd3, 16'd200, 16'd2});
        send_text(3'd7, "{\"N\":200}", 1'b0);
        repeat (4) send_event(MODE_TICK, 3'd4);
        send_event(MODE_DISCONNECT, 3'd7);
        repeat (4) send_event(MODE_TICK, 3'd7);
        send_event(MODE_CONNECT, 3'd1);
        repeat (4) send_event(MODE_TICK, 3'd2);
    endtask

    task automatic test_code_extremes();
        drain();
        write_config({16'hFFFF, 16'hFFFF, 16'hFFFE, 16'd0});
        send_text(3'd1, "{\"N\":65534}", 1'b0);
        send_text(3'd1, "{\"N\":65535}", 1'b0);
        send_text(3'd1, "{\"N\":0}\n", 1'b0);
    endtask

    task automatic test_random_traffic();
        int pick;
        shuffle_config();
        in_random = 1'b1;
        while (random_words < RANDOM_WORDS) begin
            calm = ($urandom_range(0, 9) == 0);
            if (!slot_taken && $urandom_range(0, 3) != 0)
                send_event(MODE_CONNECT, 3'($urandom_range(0, 7)));
            pick = $urandom_range(0, 19);
            if (pick <= 10) begin
                send_text(ctrl_id, make_message(), 1'b1);
            end else if (pick <= 13) begin
                repeat ($urandom_range(1, 12)) send_event(MODE_TICK, 3'($urandom_range(0, 7)));
            end else if (pick == 14) begin
                send_event(MODE_CONNECT, 3'($urandom_range(0, 7)));
            end else if (pick == 15) begin
                if ($urandom_range(0, 3) != 0) send_event(MODE_DISCONNECT, ctrl_id);
                else send_event(MODE_DISCONNECT, 3'($urandom_range(0, 7)));
            end else if (pick <= 17) begin
                repeat ($urandom_range(1, 6)) begin
                    send_event(t_mode'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
                end
            end else if (pick == 18) begin
                send_text(3'(ctrl_id + $urandom_range(1, 7)), make_message(), 1'b0);
            end else begin
                shuffle_config();
            end
        end
        in_random = 1'b0;
        calm      = 1'b0;
    endtask

    initial begin
        reset_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_first_motion_after_boot();
        test_slot_events();
        test_key_scanning();
        test_watchdog();
        test_code_extremes();
        test_random_traffic();
        drain();
        $display("sent %0d words (%0d random) over %0d cycles, checked %0d verdicts",
                 words_sent, random_words, cycle_count, verdicts);
        $display("forward %0d, drop %0d, estop %0d, reject %0d", action_tally[ACT_FORWARD],
                 action_tally[ACT_DROP], action_tally[ACT_ESTOP], action_tally[ACT_REJECT]);
        if (mismatches == 0) begin
            $display("** motion_command_supervisor_top: PASSED **");
        end else begin
            $display("** motion_command_supervisor_top: FAILED **");
        end
        $finish;
    end

endmodule
